>>> hw/rtl/aes128_block_encrypt_top_defines.svh
// assertion macros for the aes128 block encrypt checker
`ifndef AES128_BLOCK_ENCRYPT_TOP_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_TOP_DEFINES_SVH
// implication checked on every clock unless reset
`define AES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define AES_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> hw/rtl/aes_pkg.sv
// shared aes types, tables and round functions
package aes_pkg;
   localparam int unsigned Stages = 11;
   typedef logic [127:0] blk_type;
   typedef logic [7:0] byte_type;

   localparam byte_type SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam byte_type RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                     8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   localparam logic CsrKeyHigh = 1'b0;
   localparam logic CsrKeyLow  = 1'b1;

   // byte i of a block sits at bits 127-8i downto 120-8i
   function automatic byte_type get_b(blk_type v, int i);
      return v[127 - 8 * i -: 8];
   endfunction

   function automatic byte_type xtime(byte_type x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic blk_type next_key(blk_type rk, byte_type rc);
      byte_type k [16];
      byte_type t [4];
      blk_type  r;
      for (int i = 0; i < 16; i++) k[i] = get_b(rk, i);
      t[0] = SBOX[k[13]] ^ rc;
      t[1] = SBOX[k[14]];
      t[2] = SBOX[k[15]];
      t[3] = SBOX[k[12]];
      for (int i = 0; i < 4; i++) k[i] = k[i] ^ t[i];
      for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i - 4];
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = k[i];
      return r;
   endfunction

   function automatic blk_type round_fn(blk_type s, blk_type rk, logic mix);
      byte_type t [16];
      byte_type a0, a1, a2, a3, al;
      blk_type  r;
      for (int c = 0; c < 4; c++)
         for (int j = 0; j < 4; j++)
            t[j + 4 * c] = SBOX[get_b(s, j + 4 * ((c + j) & 3))];
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4 * c]     = a0 ^ al ^ xtime(a0 ^ a1);
            t[4 * c + 1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4 * c + 2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4 * c + 3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
      return r ^ rk;
   endfunction
endpackage

>>> hw/rtl/aes128_block_encrypt_top.sv
// aes-128 ecb encryption pipeline, top level
// Takes one 128-bit block per cycle while the result side does not stall. The
// transfer loads stage 0 (initial key xor) and each of the ten rounds has a
// stage of its own, so the ciphertext passes through stage 0 and the ten
// round stages before it shows on the result port. The round keys are
// expanded alongside the data: every stage carries its block's round key, so
// a key written between blocks applies to the next block at once, and
// nothing is stored per key. The whole pipeline advances together; a stall on
// the result side freezes every stage, and a new block is taken whenever the
// last stage is empty or being drained.
// Keys must be written by the user only while the pipeline is empty; the block itself does not enforce it.
module aes128_block_encrypt_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_plain_high,
   input  logic [63:0] req_plain_low,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   output logic        rsp_last_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
   localparam int unsigned N = aes_pkg::Stages;

   logic [63:0] key_hi_ff, key_lo_ff;
   logic [N-1:0] vld_ff, vld_in;
   aes_pkg::blk_type st_ff [N];
   aes_pkg::blk_type rk_ff [N];
   logic [N-1:0] last_ff;
   logic adv;

   // the whole line moves unless the last stage holds a stalled result
   assign adv       = !(vld_ff[N-1] && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            aes_pkg::CsrKeyHigh: key_hi_ff <= csr_data;
            aes_pkg::CsrKeyLow:  key_lo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign vld_in = {vld_ff[N-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   // stage 0: initial key xor; stage n: round n with its own key expansion step
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0]   <= {req_plain_high, req_plain_low} ^ {key_hi_ff, key_lo_ff};
         rk_ff[0]   <= {key_hi_ff, key_lo_ff};
         last_ff[0] <= req_last_in;
         for (int n = 1; n < N; n++) begin
            rk_ff[n]   <= aes_pkg::next_key(rk_ff[n-1], aes_pkg::RCON[n-1]);
            st_ff[n]   <= aes_pkg::round_fn(st_ff[n-1],
                             aes_pkg::next_key(rk_ff[n-1], aes_pkg::RCON[n-1]),
                             n != N - 1);
            last_ff[n] <= last_ff[n-1];
         end
      end
   end

   assign rsp_valid       = vld_ff[N-1];
   assign rsp_cipher_high = st_ff[N-1][127:64];
   assign rsp_cipher_low  = st_ff[N-1][63:0];
   assign rsp_last_out    = last_ff[N-1];
endmodule

>>> hw/rtl/aes128_block_encrypt_chk.sv
// port-level checker for the aes pipeline, with its bind
`include "aes128_block_encrypt_top_defines.svh"
module aes128_block_encrypt_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_cipher_high,
   input logic        csr_ready
);
   `AES_ASSERT_IMP(a_stall_only_full, clock, reset, req_stall,
      rsp_valid && rsp_stall, "input stalled without a stalled result")
   `AES_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_cipher_high), "stalled result changed")
   `AES_ASSERT_IMP(a_csr_ready, clock, reset, 1'b1, csr_ready, "csr port not ready")
endmodule

bind aes128_block_encrypt_top aes128_block_encrypt_chk u_chk (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cipher_high(rsp_cipher_high),
   .csr_ready(csr_ready)
);

>>> verif/tb_aes128_block_encrypt_top.sv
// testbench for the aes-128 ecb encryption pipeline
`timescale 1ns / 1ps
module tb_aes128_block_encrypt_top;
   localparam int NumRandom    = 1750;
   localparam int CycleLimit   = 400000;
   localparam int DrainCycles  = 20;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
      logic        last_in;
   } block_item_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
      logic        last_out;
   } cipher_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_plain_high = '0;
   logic [63:0] req_plain_low = '0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        rsp_last_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = aes_pkg::CsrKeyHigh;
   logic [63:0] csr_data = '0;

   // pending plaintext blocks and expected ciphertexts
   block_item_type  pending_blocks[$];
   cipher_item_type expected_ciphers[$];

   // testbench copy of the key registers
   logic [63:0] key_hi_shadow = '0;
   logic [63:0] key_lo_shadow = '0;

   int  fail_count = 0;
   int  cycle_count = 0;
   bit  long_hold = 1'b0;
   bit  hold_started = 1'b0;
   int  hold_left = 0;
   int  burst_left = 0;
   int  gap_left = 0;

   aes128_block_encrypt_top u_top (.*);

   always #2 clock = ~clock;

   // sbox for the model, built from the gf(2^8) inverse and the affine map
   logic [7:0] sub_tab [256];

   function automatic logic [7:0] gf_mul2(logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_mul2(a);
      end
      return p;
   endfunction

   initial begin
      logic [7:0] inv, b;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++)
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         b = inv;
         for (int i = 0; i < 8; i++)
            b[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
                   ^ inv[(i + 7) % 8];
         sub_tab[x] = b ^ 8'h63;
      end
   end

   // aes-128 encryption of one block under the shadow key
   function automatic cipher_item_type encrypt_block(block_item_type blk);
      logic [7:0]  st [16];
      logic [7:0]  rk [16];
      logic [7:0]  tmp [16];
      logic [7:0]  t [4];
      logic [7:0]  rc;
      logic [7:0]  a0, a1, a2, a3, al;
      logic [127:0] pt, kk;
      cipher_item_type res;
      pt = {blk.plain_high, blk.plain_low};
      kk = {key_hi_shadow, key_lo_shadow};
      for (int i = 0; i < 16; i++) begin
         st[i] = pt[127 - 8 * i -: 8] ^ kk[127 - 8 * i -: 8];
         rk[i] = kk[127 - 8 * i -: 8];
      end
      rc = 8'h01;
      for (int n = 1; n <= 10; n++) begin
         // key schedule step
         t[0] = sub_tab[rk[13]] ^ rc;
         t[1] = sub_tab[rk[14]];
         t[2] = sub_tab[rk[15]];
         t[3] = sub_tab[rk[12]];
         for (int i = 0; i < 4; i++) rk[i] ^= t[i];
         for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
         rc = gf_mul2(rc);
         // sub bytes and shift rows
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               tmp[r + 4 * c] = sub_tab[st[r + 4 * ((c + r) % 4)]];
         if (n < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = tmp[4 * c]; a1 = tmp[4 * c + 1];
               a2 = tmp[4 * c + 2]; a3 = tmp[4 * c + 3];
               al = a0 ^ a1 ^ a2 ^ a3;
               tmp[4 * c]     = a0 ^ al ^ gf_mul2(a0 ^ a1);
               tmp[4 * c + 1] = a1 ^ al ^ gf_mul2(a1 ^ a2);
               tmp[4 * c + 2] = a2 ^ al ^ gf_mul2(a2 ^ a3);
               tmp[4 * c + 3] = a3 ^ al ^ gf_mul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
      end
      for (int i = 0; i < 8; i++) begin
         res.cipher_high[63 - 8 * i -: 8] = st[i];
         res.cipher_low[63 - 8 * i -: 8]  = st[8 + i];
      end
      res.last_out = blk.last_in;
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // sender: bursts of transfers with random gaps; payload held while stalled
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_ciphers.push_back(encrypt_block(pending_blocks.pop_front()));
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_blocks.size() > 0) begin
               req_valid      <= 1'b1;
               req_plain_high <= pending_blocks[0].plain_high;
               req_plain_low  <= pending_blocks[0].plain_low;
               req_last_in    <= pending_blocks[0].last_in;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stall pattern, quiet stretches, one long hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (long_hold && !hold_started && hold_left == 0) begin
            hold_left    <= 300;
            hold_started <= 1'b1;
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (cycle_count % 2000 < 600) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   // monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      cipher_item_type exp_c;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ciphers.size() == 0) begin
            $error("unexpected result transfer");
            fail_count = fail_count + 1;
         end else begin
            exp_c = expected_ciphers.pop_front();
            if (rsp_cipher_high !== exp_c.cipher_high) begin
               $error("cipher_high expected %h got %h", exp_c.cipher_high, rsp_cipher_high);
               fail_count = fail_count + 1;
            end
            if (rsp_cipher_low !== exp_c.cipher_low) begin
               $error("cipher_low expected %h got %h", exp_c.cipher_low, rsp_cipher_low);
               fail_count = fail_count + 1;
            end
            if (rsp_last_out !== exp_c.last_out) begin
               $error("last_out expected %b got %b", exp_c.last_out, rsp_last_out);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("aes128_block_encrypt_top verification failed");
         $finish;
      end
   end

   // key write over the csr channel, only with the pipeline empty
   task automatic write_key(logic idx, logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == aes_pkg::CsrKeyHigh) key_hi_shadow = val;
      else key_lo_shadow = val;
   endtask

   task automatic wait_empty();
      while (pending_blocks.size() > 0 || req_valid || expected_ciphers.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic queue_block(logic [63:0] hi, logic [63:0] lo, logic last);
      pending_blocks.push_back('{plain_high: hi, plain_low: lo, last_in: last});
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // zero key at reset, extreme blocks
      queue_block('0, '0, 1'b0);
      queue_block('1, '1, 1'b1);
      queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
      queue_block(64'h8000000000000000, 64'h0000000000000001, 1'b1);
      wait_empty();

      // fips-197 appendix c.1 key
      write_key(aes_pkg::CsrKeyHigh, 64'h0001020304050607);
      write_key(aes_pkg::CsrKeyLow,  64'h08090a0b0c0d0e0f);
      queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
      // fips-197 appendix b vector
      wait_empty();
      write_key(aes_pkg::CsrKeyHigh, 64'h2b7e151628aed2a6);
      write_key(aes_pkg::CsrKeyLow,  64'habf7158809cf4f3c);
      queue_block(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1);
      queue_block('0, '1, 1'b0);
      queue_block('1, '0, 1'b1);
      wait_empty();

      // all-ones key, then a key change between single blocks
      write_key(aes_pkg::CsrKeyHigh, '1);
      write_key(aes_pkg::CsrKeyLow,  '1);
      queue_block('0, '0, 1'b1);
      queue_block('1, '1, 1'b0);
      wait_empty();
      write_key(aes_pkg::CsrKeyLow, '0);
      queue_block('1, '1, 1'b1);
      wait_empty();

      // random phases with new keys; one phase has a long receiver hold-off
      for (int ph = 0; ph < 7; ph++) begin
         write_key(aes_pkg::CsrKeyHigh, rand64());
         write_key(aes_pkg::CsrKeyLow,  rand64());
         for (int i = 0; i < NumRandom / 7; i++)
            queue_block(rand64(), rand64(), $urandom_range(0, 1));
         if (ph == 2) long_hold = 1'b1;
         wait_empty();
      end

      if (fail_count == 0 && expected_ciphers.size() == 0) begin
         $display("aes128_block_encrypt_top verification clean");
      end else begin
         $display("aes128_block_encrypt_top verification failed");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/aes_pkg.sv
hw/rtl/aes128_block_encrypt_top.sv
hw/rtl/aes128_block_encrypt_chk.sv
verif/tb_aes128_block_encrypt_top.sv
